/* sv/glmf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glmf_pkg
// Shared widths, register indexes and bundle types of the grid local maximum
// finder.
// ----------------------------------------------------------------------------
package glmf_pkg;

  localparam int VALUE_W    = 16;
  localparam int ROW_W      = 12;
  localparam int MAX_COLS   = 256;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int COLCNT_W   = $clog2(MAX_COLS + 1);
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 1;

  // results one pixel can release
  localparam int MAX_RES    = 3;
  localparam int RES_CW     = $clog2(MAX_RES + 1);

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

  localparam logic [ROW_W-1:0]    ROW_COUNT_RST = 12'd4;
  localparam logic [COLCNT_W-1:0] COL_COUNT_RST = 9'd4;

  // position of an accepted pixel and which neighbours exist around it
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             has_above;  // row >= 1
    logic             has_up;     // row >= 2
    logic             has_left;   // col >= 1
    logic             has_left2;  // col >= 2
    logic             has_right;  // col + 1 < cols
    logic             last_row;
    logic             last_col;
  } pos_t;

  typedef struct packed {
    logic                      en;
    logic [COL_W-1:0]          addr;
    logic signed [VALUE_W-1:0] older;
    logic signed [VALUE_W-1:0] recent;
  } ram_wr_t;

  typedef struct packed {
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
    logic signed [VALUE_W-1:0] value;
  } peak_t;

  typedef struct packed {
    peak_t pk;
    logic  last;
  } res_ent_t;

  // reports of one pixel, packed in raster order into the low slots
  typedef struct packed {
    logic [RES_CW-1:0]        n;
    peak_t [MAX_RES-1:0]      ent;
  } res_bundle_t;

endpackage

/* sv/glmf_line_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glmf_line_ram
// Line memory: one word per column holding the two previous rows. One write
// and one read port, registered read, write-first on an address collision.
// ----------------------------------------------------------------------------
module glmf_line_ram (
  input  logic                               clk_i,
  input  glmf_pkg::ram_wr_t                  wr_i,
  input  logic                               re_i,
  input  logic [glmf_pkg::COL_W-1:0]         raddr_i,
  output logic signed [glmf_pkg::VALUE_W-1:0] rd_older_o,
  output logic signed [glmf_pkg::VALUE_W-1:0] rd_recent_o
);
  import glmf_pkg::*;

  logic [2*VALUE_W-1:0] mem [MAX_COLS];
  logic [2*VALUE_W-1:0] rdata_q;
  logic [2*VALUE_W-1:0] wdata;

  assign wdata = {wr_i.older, wr_i.recent};

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wdata;
    end
    if (re_i) begin
      if (wr_i.en && (wr_i.addr == raddr_i)) begin
        rdata_q <= wdata;
      end else begin
        rdata_q <= mem[raddr_i];
      end
    end
  end

  assign rd_older_o  = rdata_q[2*VALUE_W-1:VALUE_W];
  assign rd_recent_o = rdata_q[VALUE_W-1:0];

endmodule

/* sv/glmf_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glmf_window
// Neighbourhood stage: holds the window around the current column, judges
// the up to three cells a pixel completes and writes the line memory back.
// ----------------------------------------------------------------------------
module glmf_window (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                acc_i,
  input  glmf_pkg::pos_t                      pos_i,
  input  logic signed [glmf_pkg::VALUE_W-1:0] pix_i,
  input  logic signed [glmf_pkg::VALUE_W-1:0] rd_older_i,
  input  logic signed [glmf_pkg::VALUE_W-1:0] rd_recent_i,
  output glmf_pkg::ram_wr_t                   wr_o,
  output glmf_pkg::res_bundle_t               bundle_o
);
  import glmf_pkg::*;

  logic                      s1_vld_q;
  pos_t                      s1_pos_q;
  logic signed [VALUE_W-1:0] s1_pix_q;
  // row r-1 and r-2 at the current column, row r-1 one column back
  logic signed [VALUE_W-1:0] col_rec_q;
  logic signed [VALUE_W-1:0] col_old_q;
  logic signed [VALUE_W-1:0] left_q;
  // last two pixels of the current row
  logic signed [VALUE_W-1:0] pv1_q;
  logic signed [VALUE_W-1:0] pv2_q;

  logic  [MAX_RES-1:0] hit;
  peak_t [MAX_RES-1:0] cand;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= acc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_pos_q <= pos_i;
      s1_pix_q <= pix_i;
    end
    if (s1_vld_q) begin
      // read data here is the next column, prefetched at accept
      col_rec_q <= rd_recent_i;
      col_old_q <= rd_older_i;
      left_q    <= col_rec_q;
      pv1_q     <= s1_pix_q;
      pv2_q     <= pv1_q;
    end
  end

  always_comb begin
    wr_o.en     = s1_vld_q;
    wr_o.addr   = s1_pos_q.col;
    wr_o.older  = col_rec_q;
    wr_o.recent = s1_pix_q;
  end

  always_comb begin
    // cell above the new pixel, its lower neighbour just arrived
    cand[0].row   = s1_pos_q.row - ROW_W'(1);
    cand[0].col   = s1_pos_q.col;
    cand[0].value = col_rec_q;
    hit[0] = s1_vld_q && s1_pos_q.has_above
          && (!s1_pos_q.has_up    || (col_rec_q > col_old_q))
          && (col_rec_q > s1_pix_q)
          && (!s1_pos_q.has_left  || (col_rec_q > left_q))
          && (!s1_pos_q.has_right || (col_rec_q > rd_recent_i));

    // last row: cell to the left, its right neighbour just arrived
    cand[1].row   = s1_pos_q.row;
    cand[1].col   = s1_pos_q.col - COL_W'(1);
    cand[1].value = pv1_q;
    hit[1] = s1_vld_q && s1_pos_q.last_row && s1_pos_q.has_left
          && (pv1_q > left_q)
          && (!s1_pos_q.has_left2 || (pv1_q > pv2_q))
          && (pv1_q > s1_pix_q);

    // bottom-right corner
    cand[2].row   = s1_pos_q.row;
    cand[2].col   = s1_pos_q.col;
    cand[2].value = s1_pix_q;
    hit[2] = s1_vld_q && s1_pos_q.last_row && s1_pos_q.last_col
          && (s1_pix_q > col_rec_q)
          && (s1_pix_q > pv1_q);
  end

  // pack hits into the low slots, raster order kept
  always_comb begin
    bundle_o.n = RES_CW'(hit[0]) + RES_CW'(hit[1]) + RES_CW'(hit[2]);
    bundle_o.ent[0] = hit[0] ? cand[0] : (hit[1] ? cand[1] : cand[2]);
    bundle_o.ent[1] = (hit[0] && hit[1]) ? cand[1] : cand[2];
    bundle_o.ent[2] = cand[2];
  end

endmodule

/* sv/glmf_result_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glmf_result_fifo
// Report queue: takes up to three reports a cycle, hands out one per beat,
// and flags whether another pixel's worth of reports still fits.
// ----------------------------------------------------------------------------
module glmf_result_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  glmf_pkg::res_bundle_t bundle_i,
  input  logic                  pop_i,
  output logic                  valid_o,
  output glmf_pkg::res_ent_t    ent_o,
  output logic                  room_o
);
  import glmf_pkg::*;

  res_ent_t           mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0] count_q, count_d;
  logic [FIFO_CW-1:0] pend;

  assign valid_o = (count_q != '0);
  assign ent_o   = mem[rd_ptr_q];

  // slots already in the queue plus this cycle's writes; a pixel taken now
  // lands in the next cycle with up to three more
  assign pend   = count_q + FIFO_CW'(bundle_i.n);
  assign room_o = (pend <= FIFO_CW'(FIFO_DEPTH - MAX_RES));

  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_AW'(bundle_i.n);
    rd_ptr_d = rd_ptr_q + FIFO_AW'(pop_i);
    count_d  = pend - FIFO_CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (RES_CW'(k) < bundle_i.n) begin
        mem[FIFO_AW'(wr_ptr_q + FIFO_AW'(k))].pk   <= bundle_i.ent[k];
        mem[FIFO_AW'(wr_ptr_q + FIFO_AW'(k))].last <=
          (RES_CW'(k) + RES_CW'(1) == bundle_i.n);
      end
    end
  end

endmodule

/* sv/grid_local_maximum_finder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_local_maximum_finder_unit
// Streaming four-neighbour local maximum finder over a raster-order grid.
// ----------------------------------------------------------------------------
// Takes one signed pixel per cycle while ready, in raster order and reports
// each cell strictly greater than every neighbour it has (up, down, left,
// right). A cell is judged in the beat of the pixel that completes its
// neighbourhood; its reports pass the window stage register and the queue, in raster
// order, with last_of_run on the final report of each pixel. The pace is set
// by one line memory (one word per column holding the two previous rows)
// that is read one column ahead at accept and written back the next cycle;
// a same-address read and write is forwarded. Reports drain, one per ready beat,
// through an eight-entry queue; pixel_ready_o drops while the queue could not
// take three more. Writing row_count or col_count restarts the frame and must
// only happen while the block is idle. The line memory needs no clearing.
module grid_local_maximum_finder_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [glmf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [glmf_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                 pixel_valid_i,
  output logic                                 pixel_ready_o,
  input  logic signed [glmf_pkg::VALUE_W-1:0]  pixel_value_i,
  output logic                                 peak_valid_o,
  input  logic                                 peak_ready_i,
  output logic [glmf_pkg::ROW_W-1:0]           peak_row_o,
  output logic [glmf_pkg::COL_W-1:0]           peak_col_o,
  output logic signed [glmf_pkg::VALUE_W-1:0]  peak_value_o,
  output logic                                 last_of_run_o
);
  import glmf_pkg::*;

  logic [ROW_W-1:0]    row_count_q;
  logic [COLCNT_W-1:0] col_count_q;
  logic [ROW_W-1:0]    row_cnt_q, row_cnt_d;
  logic [COL_W-1:0]    col_cnt_q, col_cnt_d;

  logic [ROW_W-1:0]    rows_eff;
  logic [COLCNT_W-1:0] cols_eff;
  logic                wrap;
  logic [ROW_W-1:0]    cur_row;
  logic [COL_W-1:0]    cur_col;
  logic [COLCNT_W-1:0] col_nx;
  logic                has_right;
  logic                last_row;
  pos_t                pos;
  logic [COL_W-1:0]    raddr;
  logic                acc;

  ram_wr_t                   ram_wr;
  logic signed [VALUE_W-1:0] rd_older;
  logic signed [VALUE_W-1:0] rd_recent;
  res_bundle_t               bundle;
  res_ent_t                  head;
  logic                      room;

  assign acc = pixel_valid_i && pixel_ready_o;

  always_comb begin
    rows_eff = (row_count_q < ROW_W'(2)) ? ROW_W'(2) : row_count_q;
    if (col_count_q > COLCNT_W'(MAX_COLS)) begin
      cols_eff = COLCNT_W'(MAX_COLS);
    end else if (col_count_q < COLCNT_W'(2)) begin
      cols_eff = COLCNT_W'(2);
    end else begin
      cols_eff = col_count_q;
    end

    wrap    = (row_cnt_q >= rows_eff) || ({1'b0, col_cnt_q} >= cols_eff);
    cur_row = wrap ? '0 : row_cnt_q;
    cur_col = wrap ? '0 : col_cnt_q;

    col_nx    = {1'b0, cur_col} + COLCNT_W'(1);
    has_right = (col_nx < cols_eff);
    last_row  = (cur_row == rows_eff - ROW_W'(1));

    pos.row       = cur_row;
    pos.col       = cur_col;
    pos.has_above = (cur_row >= ROW_W'(1));
    pos.has_up    = (cur_row >= ROW_W'(2));
    pos.has_left  = (cur_col >= COL_W'(1));
    pos.has_left2 = (cur_col >= COL_W'(2));
    pos.has_right = has_right;
    pos.last_row  = last_row;
    pos.last_col  = !has_right;

    // prefetch the next column; at row end that is column 0 of the next row
    raddr = has_right ? col_nx[COL_W-1:0] : '0;

    if (has_right) begin
      col_cnt_d = col_nx[COL_W-1:0];
      row_cnt_d = cur_row;
    end else begin
      col_cnt_d = '0;
      row_cnt_d = last_row ? '0 : cur_row + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROW_COUNT_RST;
      col_count_q <= COL_COUNT_RST;
      row_cnt_q   <= '0;
      col_cnt_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ROW_COUNT: row_count_q <= cfg_data_i;
        REG_COL_COUNT: col_count_q <= cfg_data_i[COLCNT_W-1:0];
        default:       ;
      endcase
      row_cnt_q <= '0;
      col_cnt_q <= '0;
    end else if (acc) begin
      row_cnt_q <= row_cnt_d;
      col_cnt_q <= col_cnt_d;
    end
  end

  glmf_line_ram u_line_ram (
    .clk_i       (clk_i),
    .wr_i        (ram_wr),
    .re_i        (acc),
    .raddr_i     (raddr),
    .rd_older_o  (rd_older),
    .rd_recent_o (rd_recent)
  );

  glmf_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .pos_i       (pos),
    .pix_i       (pixel_value_i),
    .rd_older_i  (rd_older),
    .rd_recent_i (rd_recent),
    .wr_o        (ram_wr),
    .bundle_o    (bundle)
  );

  glmf_result_fifo u_result_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .bundle_i (bundle),
    .pop_i    (peak_valid_o && peak_ready_i),
    .valid_o  (peak_valid_o),
    .ent_o    (head),
    .room_o   (room)
  );

  assign pixel_ready_o = room;
  assign peak_row_o    = head.pk.row;
  assign peak_col_o    = head.pk.col;
  assign peak_value_o  = head.pk.value;
  assign last_of_run_o = head.last;

endmodule
